// ===== design/bhu_pkg.sv =====
// ----------------------------------------------------------------------------
// bhu_pkg: shared types and constants for the backslash/hex unescape decoder
// Decode phases, escape characters, hex digit lookup and the result record.
// ----------------------------------------------------------------------------
package bhu_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_HEX1  = 2'd2,
    PH_HEX2  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       ok;
  } hex_digit_t;

  // one result beat, valid marks that the input beat produced a result
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       byte_valid;
    logic       done;
    logic       error;
  } res_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t h;
    logic [7:0] t;
    h = '{nibble: 4'd0, ok: 1'b0};
    t = 8'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      t = b - 8'h30;
      h = '{nibble: t[3:0], ok: 1'b1};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      t = b - 8'h57;
      h = '{nibble: t[3:0], ok: 1'b1};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      t = b - 8'h37;
      h = '{nibble: t[3:0], ok: 1'b1};
    end
    return h;
  endfunction

endpackage

// ===== design/bhu_in_stage.sv =====
// ----------------------------------------------------------------------------
// bhu_in_stage: input register
// Holds one accepted beat until the decoder consumes it.
// ----------------------------------------------------------------------------
module bhu_in_stage import bhu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_last
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;

  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;
  assign held_last  = last_r;

endmodule

// ===== design/bhu_decode.sv =====
// ----------------------------------------------------------------------------
// bhu_decode: escape decoder step
// Phase, pending nibble and discard flag, plus the per-beat decode logic.
// ----------------------------------------------------------------------------
module bhu_decode import bhu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [7:0] cur_byte,
  input  logic       cur_last,
  output res_t       res
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] hi_r, hi_nxt;
  logic       disc_r, disc_nxt;

  hex_digit_t hd;
  logic       have_byte;
  logic       bad;
  logic       err_end;
  logic [7:0] value;

  assign hd = hex_decode(cur_byte);

  always_comb begin
    phase_nxt = phase_r;
    hi_nxt    = hi_r;
    disc_nxt  = disc_r;
    have_byte = 1'b0;
    bad       = 1'b0;
    err_end   = 1'b0;
    value     = 8'd0;
    res       = '{valid: 1'b0, data: 8'd0, byte_valid: 1'b0, done: 1'b0, error: 1'b0};

    if (disc_r) begin
      if (cur_last) begin
        res      = '{valid: 1'b1, data: 8'd0, byte_valid: 1'b0, done: 1'b1, error: 1'b1};
        disc_nxt = 1'b0;
      end
    end else begin
      unique case (phase_r)
        PH_PLAIN: begin
          if (cur_byte == CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            have_byte = 1'b1;
            value     = cur_byte;
          end
        end
        PH_ESC: begin
          if (cur_byte == CH_QUOTE || cur_byte == CH_BSLASH) begin
            have_byte = 1'b1;
            value     = cur_byte;
            phase_nxt = PH_PLAIN;
          end else if (cur_byte == CH_X) begin
            phase_nxt = PH_HEX1;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HEX1: begin
          if (hd.ok) begin
            hi_nxt    = hd.nibble;
            phase_nxt = PH_HEX2;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HEX2: begin
          if (hd.ok) begin
            have_byte = 1'b1;
            value     = {hi_r, hd.nibble};
            hi_nxt    = 4'd0;
            phase_nxt = PH_PLAIN;
          end else begin
            bad = 1'b1;
          end
        end
        default: bad = 1'b1;
      endcase

      if (cur_last) begin
        // a string that stops with an escape still open is an error too
        err_end   = bad || (!have_byte && phase_nxt != PH_PLAIN);
        phase_nxt = PH_PLAIN;
        hi_nxt    = 4'd0;
        if (err_end) begin
          res = '{valid: 1'b1, data: 8'd0, byte_valid: 1'b0, done: 1'b1, error: 1'b1};
        end else begin
          res = '{valid: 1'b1, data: value, byte_valid: have_byte, done: 1'b1,
                  error: 1'b0};
        end
      end else if (bad) begin
        phase_nxt = PH_PLAIN;
        hi_nxt    = 4'd0;
        disc_nxt  = 1'b1;
        res       = '{valid: 1'b1, data: 8'd0, byte_valid: 1'b0, done: 1'b0, error: 1'b1};
      end else if (have_byte) begin
        res = '{valid: 1'b1, data: value, byte_valid: 1'b1, done: 1'b0, error: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      hi_r    <= 4'd0;
      disc_r  <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      hi_r    <= hi_nxt;
      disc_r  <= disc_nxt;
    end
  end

  a_disc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (phase_r == PH_PLAIN && hi_r == 4'd0))
    else $error("discard mode with escape state pending");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cur_last) |=> (phase_r == PH_PLAIN && hi_r == 4'd0 && !disc_r))
    else $error("state not cleared after last beat");

  a_err_discards: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.valid && res.error && !res.done) |=> disc_r)
    else $error("mid-string error did not start discarding");

  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cur_last) |-> (res.valid && res.done))
    else $error("last beat without a done result");

endmodule

// ===== design/bhu_out_stage.sv =====
// ----------------------------------------------------------------------------
// bhu_out_stage: result register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module bhu_out_stage import bhu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       res,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_done_res,
  output logic       out_error
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       bv_r;
  logic       done_r;
  logic       err_r;

  assign can_load = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      byte_r <= res.data;
      bv_r   <= res.byte_valid;
      done_r <= res.done;
      err_r  <= res.error;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bv_r;
  assign out_done_res   = done_r;
  assign out_error      = err_r;

endmodule

// ===== design/backslash_hex_unescape_decoder.sv =====
// ----------------------------------------------------------------------------
// backslash_hex_unescape_decoder: streaming unescaper for \" \\ and \xHH
// Decodes one byte of an escaped string per beat into zero or one results.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_byte and in_last (last byte of a
// string). Result channel: out_valid/out_stall with out_byte, out_byte_valid,
// out_done_res and out_error. A beat moves when valid is high and stall low.
// Bytes that open or continue an escape give no result; every last byte
// gives a result with out_done_res set.
// A beat accepted into the input register is decoded from it, and its result
// is loaded into the result register. Throughput is one byte per cycle while
// the receiver does not stall; phase and hex nibble are decoded combinationally.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to plain text with no pending escape or discard.
// When the receiver stalls, the result register holds; one more input beat
// is still accepted into the input register, after which in_stall rises
// until the result is taken.
// ----------------------------------------------------------------------------
module backslash_hex_unescape_decoder import bhu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_done_res,
  output logic       out_error
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_last;
  logic       can_load;
  logic       advance;
  res_t       res;

  assign advance = held_valid && can_load;

  bhu_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_last  (held_last)
  );

  bhu_decode u_dec (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .cur_byte (held_byte),
    .cur_last (held_last),
    .res      (res)
  );

  bhu_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (advance),
    .res            (res),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_done_res   (out_done_res),
    .out_error      (out_error)
  );

  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (held_valid && !out_valid) |-> !in_stall)
    else $error("input stalled with an empty result register");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !held_valid |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(advance))
    else $error("result appeared without a decoded beat");

endmodule

// ===== dv/unescape_checker.sv =====
// ----------------------------------------------------------------------------
// unescape_checker: result predictor and comparator for the unescape decoder
// Watches both channels, decodes every accepted input beat with its own copy
// of the escape state, queues the result it should cause and compares each
// accepted result beat field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module unescape_checker import bhu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_byte_valid,
  input  logic       out_done_res,
  input  logic       out_error,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       done;
    logic       error;
  } unesc_res_t;

  localparam logic [4:0] NOT_HEX = 5'h10;
  localparam int         QDEPTH  = 64;

  phase_t     phase;
  logic [3:0] hi_nib;
  logic       dropping;

  // ring of predicted results, oldest at rd_ptr
  unesc_res_t exp_mem[QDEPTH];
  logic [5:0] wr_ptr;
  logic [5:0] rd_ptr;
  int         exp_cnt;

  // digit value in [3:0], bit 4 set when the byte is no hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      return {1'b0, c[3:0] + 4'd9};
    return NOT_HEX;
  endfunction

  task automatic clear_state();
    phase    = PH_PLAIN;
    hi_nib   = 4'd0;
    dropping = 1'b0;
  endtask

  task automatic queue_result(input logic [7:0] data, input logic bv,
                              input logic done, input logic err);
    if (exp_cnt == QDEPTH) begin
      $error("too many results outstanding, prediction dropped");
      fail_count++;
      return;
    end
    exp_mem[wr_ptr] = '{data: data, byte_valid: bv, done: done, error: err};
    wr_ptr = wr_ptr + 6'd1;
    exp_cnt++;
  endtask

  task automatic decode_beat(input logic [7:0] b, input logic last);
    logic       have;
    logic       bad;
    logic [7:0] value;
    logic [4:0] d;
    have  = 1'b0;
    bad   = 1'b0;
    value = 8'd0;
    d     = hex_digit(b);
    if (dropping) begin
      if (last) begin
        clear_state();
        queue_result(8'd0, 1'b0, 1'b1, 1'b1);
      end
      return;
    end
    case (phase)
      PH_PLAIN: begin
        if (b == CH_BSLASH) phase = PH_ESC;
        else begin
          have  = 1'b1;
          value = b;
        end
      end
      PH_ESC: begin
        if (b == CH_QUOTE || b == CH_BSLASH) begin
          have  = 1'b1;
          value = b;
          phase = PH_PLAIN;
        end else if (b == CH_X) begin
          phase = PH_HEX1;
        end else begin
          bad = 1'b1;
        end
      end
      PH_HEX1: begin
        if (!d[4]) begin
          hi_nib = d[3:0];
          phase  = PH_HEX2;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        if (!d[4]) begin
          have   = 1'b1;
          value  = {hi_nib, d[3:0]};
          hi_nib = 4'd0;
          phase  = PH_PLAIN;
        end else begin
          bad = 1'b1;
        end
      end
    endcase
    if (last) begin
      // a string that stops with an escape still open counts as bad too
      if (bad || (!have && phase != PH_PLAIN))
        queue_result(8'd0, 1'b0, 1'b1, 1'b1);
      else if (have)
        queue_result(value, 1'b1, 1'b1, 1'b0);
      else
        queue_result(8'd0, 1'b0, 1'b1, 1'b0);
      clear_state();
    end else if (bad) begin
      phase    = PH_PLAIN;
      hi_nib   = 4'd0;
      dropping = 1'b1;
      queue_result(8'd0, 1'b0, 1'b0, 1'b1);
    end else if (have) begin
      queue_result(value, 1'b1, 1'b0, 1'b0);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_result();
    unesc_res_t e;
    if (exp_cnt == 0) begin
      $error("result beat with nothing expected: out_byte %0h valid %0b done %0b error %0b",
             out_byte, out_byte_valid, out_done_res, out_error);
      fail_count++;
      return;
    end
    e = exp_mem[rd_ptr];
    rd_ptr = rd_ptr + 6'd1;
    exp_cnt--;
    check_field("out_byte", e.data, out_byte);
    check_field("out_byte_valid", {7'd0, e.byte_valid}, {7'd0, out_byte_valid});
    check_field("out_done_res", {7'd0, e.done}, {7'd0, out_done_res});
    check_field("out_error", {7'd0, e.error}, {7'd0, out_error});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      wr_ptr     = 6'd0;
      rd_ptr     = 6'd0;
      exp_cnt    = 0;
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) decode_beat(in_byte, in_last);
    end
    pending <= exp_cnt;
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for backslash_hex_unescape_decoder
// Feeds directed and random escaped strings with random idle cycles on both
// channels plus one long result hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb import bhu_pkg::*;;

  localparam int MAX_BYTES = 2048;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'd0;
  logic       in_last   = 1'b0;
  logic       out_stall = 1'b1;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_done_res;
  logic       out_error;
  int         fail_count;
  int         pending;

  logic [7:0] str_bytes[MAX_BYTES];
  logic       str_last[MAX_BYTES];
  int         n_bytes = 0;

  backslash_hex_unescape_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_done_res   (out_done_res),
    .out_error      (out_error)
  );

  unescape_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_done_res   (out_done_res),
    .out_error      (out_error),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // every fourth stretch of 64 beats runs without idle cycles
  function automatic int pick_gap(input int n);
    if (((n >> 6) % 4) == 1) return 0;
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  task automatic put(input logic [7:0] b, input logic l);
    str_bytes[n_bytes] = b;
    str_last[n_bytes]  = l;
    n_bytes++;
  endtask

  task automatic add_string();
    logic [7:0] s[64];
    int         ns;
    int         n;
    int         kind;
    ns = 0;
    n  = $urandom_range(1, 10);
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        s[ns] = 8'($urandom_range(0, 255));
        ns++;
      end else if (kind < 60) begin
        s[ns] = CH_BSLASH;
        ns++;
        s[ns] = $urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH;
        ns++;
      end else if (kind < 85) begin
        s[ns] = CH_BSLASH;
        ns++;
        s[ns] = CH_X;
        ns++;
        s[ns] = hex_char();
        ns++;
        s[ns] = hex_char();
        ns++;
      end else if (kind < 93) begin
        // broken escape: arbitrary byte after the backslash, or arbitrary byte in a hex slot
        s[ns] = CH_BSLASH;
        ns++;
        case ($urandom_range(0, 2))
          0: begin
            s[ns] = 8'($urandom_range(0, 255));
            ns++;
          end
          1: begin
            s[ns] = CH_X;
            ns++;
            s[ns] = 8'($urandom_range(0, 255));
            ns++;
          end
          default: begin
            s[ns] = CH_X;
            ns++;
            s[ns] = hex_char();
            ns++;
            s[ns] = 8'($urandom_range(0, 255));
            ns++;
          end
        endcase
      end else begin
        // string cut off inside an escape
        s[ns] = CH_BSLASH;
        ns++;
        if ($urandom_range(0, 2) != 0) begin
          s[ns] = CH_X;
          ns++;
        end
        if ($urandom_range(0, 1) != 0 && s[ns-1] == CH_X) begin
          s[ns] = hex_char();
          ns++;
        end
        break;
      end
    end
    for (int i = 0; i < ns; i++) put(s[i], i == ns - 1);
  endtask

  task automatic build_stimulus();
    // plain extremes
    put(8'h00, 1'b0); put(8'hFF, 1'b1);
    // quote and backslash escapes
    put(CH_BSLASH, 1'b0); put(CH_QUOTE, 1'b0);
    put(CH_BSLASH, 1'b0); put(CH_BSLASH, 1'b0);
    // hex escapes, digit range ends in both cases
    put(CH_BSLASH, 1'b0); put(CH_X, 1'b0); put(8'h30, 1'b0); put(8'h39, 1'b0);
    put(CH_BSLASH, 1'b0); put(CH_X, 1'b0); put(8'h61, 1'b0); put(8'h46, 1'b1);
    // unknown escape letter, then dropped bytes up to the last one
    put(CH_BSLASH, 1'b0); put(8'h71, 1'b0); put(CH_X, 1'b0); put(8'h41, 1'b1);
    // string ending right after a backslash
    put(CH_BSLASH, 1'b1);
    // bad first hex digit on the last byte
    put(CH_BSLASH, 1'b0); put(CH_X, 1'b0); put(8'h67, 1'b1);
    // string ending between the two hex digits
    put(CH_BSLASH, 1'b0); put(CH_X, 1'b0); put(8'h34, 1'b1);
    while (n_bytes < 1150) add_string();
  endtask

  // input side
  initial begin
    int gap;
    bit hit;
    build_stimulus();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < n_bytes; i++) begin
      gap = pick_gap(i);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= str_bytes[i];
      in_last  <= str_last[i];
      do begin
        @(negedge clk);
        hit = !in_stall;
        @(posedge clk);
      end while (!hit);
    end
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side; one long hold-off lets the decoder fill up and stall its input
  initial begin
    int gap;
    int taken;
    bit hit;
    taken = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = (taken == 300) ? 250 : pick_gap(taken);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        hit = out_valid;
        @(posedge clk);
      end while (!hit);
      taken++;
    end
  end

endmodule
